### rtl/core/greedy_pwl_segmenter_core_macros.svh
// Assertion macros shared by the greedy PWL segmenter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef GREEDY_PWL_SEGMENTER_CORE_MACROS_SVH
`define GREEDY_PWL_SEGMENTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GPWL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPWL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gpwl_pkg.sv
// Package for the greedy PWL segmenter: field widths, FSM and opcode types.
// No dependencies.
`default_nettype none

package gpwl_pkg;

   localparam int KEY_W        = 32;
   localparam int THRESH_W     = 16;
   localparam int BOUNDARY_W   = 12;
   localparam int LIMIT_W      = 48;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_MUL,
      ST_CHK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LIMIT,
      OP_ERROR
   } op_type;

   typedef struct packed {
      op_type op;
      logic   acc_load;
      logic   acc_step;
   } err_ctrl_type;

endpackage

`default_nettype wire

### rtl/core/greedy_pwl_segmenter_core.sv
// Greedy piecewise-linear segmenter, top level: sequencer, key store and
// shared error unit. Depends on gpwl_pkg, gpwl_key_ram, gpwl_err_unit and greedy_pwl_segmenter_core_macros.svh.
//
// Usage: keys of one sorted set arrive on req_ (req_key, req_set_end marks
// the last key). Boundary positions leave on rsp_ (rsp_boundary,
// rsp_final_boundary, rsp_overflow, rsp_last_of_run); an input transaction
// yields zero, one or two response transactions. The threshold is written on
// csr_ (always ready), by the user only while the block is idle; the block does not enforce it.
// Sequence: a key that needs no fit check goes from ST_IDLE to ST_EMIT,
// which registers its response, if any, once the output register is free.
// A key at position r with segment start l passes ST_LIMIT, then tests up
// to r-l-1 interior keys, each in one ST_MUL and ST_CHK pass (one memory
// read plus one pass of the shared multiplier), then ST_EMIT; a second response takes another pass through ST_EMIT.
// req_ready is high only between transactions.
// The response sits in an output register; while the receiver stalls the
// block holds it and finishes the current key, then waits before pushing
// the next response. Reset (synchronous) empties the set, drops pending
// responses and restores the threshold to 128 (0.5). The key store is not
// cleared: only entries of the current set are ever read.
`default_nettype none

module greedy_pwl_segmenter_core import gpwl_pkg::*; #(
   parameter int MAX_POINTS       = 4096,
   parameter int THRESH_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KEY_W-1:0]      req_key,
   input  logic                  req_set_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BOUNDARY_W-1:0] rsp_boundary,
   output logic                  rsp_final_boundary,
   output logic                  rsp_overflow,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [THRESH_W-1:0]   csr_data
);

   `include "greedy_pwl_segmenter_core_macros.svh"

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   // Control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    seg_ff, seg_in;
   logic                 brk_pend_ff, brk_pend_in;
   logic                 tail_pend_ff, tail_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [THRESH_W-1:0]  thresh_ff;

   // Payload state
   logic [KEY_W-1:0]      xl_ff, xl_in;
   logic [KEY_W-1:0]      prev_key_ff, prev_key_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEY_W-1:0]      dx_ff, dx_in;
   logic [ADDR_W-1:0]     r_ff, r_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic                  end_ff, end_in;
   logic [ADDR_W-1:0]     brk_pos_ff, brk_pos_in;
   logic [ADDR_W-1:0]     tail_pos_ff, tail_pos_in;
   logic                  tail_fin_ff, tail_fin_in;
   logic                  tail_ovf_ff, tail_ovf_in;
   logic [BOUNDARY_W-1:0] rsp_boundary_ff, rsp_boundary_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Datapath hookup
   err_ctrl_type          ctrl;
   logic                  exceeds;
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [KEY_W-1:0]      rd_data;
   logic [ADDR_W-1:0]     r_cur;
   logic                  full;
   logic [ADDR_W-1:0]     span;

   assign r_cur = count_ff[ADDR_W-1:0];
   assign full  = (count_ff == CNT_W'(MAX_POINTS));
   assign span  = r_ff - seg_ff;

   gpwl_key_ram #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W),
      .DATA_W (KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (r_cur),
      .wr_data (req_key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gpwl_err_unit #(
      .ADDR_W    (ADDR_W),
      .FRAC_BITS (THRESH_FRAC_BITS)
   ) u_err (
      .clock     (clock),
      .reset     (reset),
      .ctrl_i    (ctrl),
      .threshold (thresh_ff),
      .dx        (dx_ff),
      .key_i     (rd_data),
      .key_l     (xl_ff),
      .span      (span),
      .exceeds   (exceeds)
   );

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      seg_in          = seg_ff;
      brk_pend_in     = brk_pend_ff;
      tail_pend_in    = tail_pend_ff;
      rsp_valid_in    = rsp_valid_ff;
      xl_in           = xl_ff;
      prev_key_in     = prev_key_ff;
      key_in          = key_ff;
      dx_in           = dx_ff;
      r_in            = r_ff;
      idx_in          = idx_ff;
      end_in          = end_ff;
      brk_pos_in      = brk_pos_ff;
      tail_pos_in     = tail_pos_ff;
      tail_fin_in     = tail_fin_ff;
      tail_ovf_in     = tail_ovf_ff;
      rsp_boundary_in = rsp_boundary_ff;
      rsp_final_in    = rsp_final_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      rsp_last_in     = rsp_last_ff;
      ctrl.op         = OP_NONE;
      ctrl.acc_load   = 1'b0;
      ctrl.acc_step   = 1'b0;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = idx_ff + ADDR_W'(1);

      // Retire the response once taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (full) begin
                  // Drop the key; flag it, closing the set if marked last.
                  brk_pend_in  = 1'b0;
                  tail_pend_in = 1'b1;
                  tail_pos_in  = req_set_end ? ADDR_W'(MAX_POINTS - 1) : '0;
                  tail_fin_in  = req_set_end;
                  tail_ovf_in  = 1'b1;
                  if (req_set_end) begin
                     count_in = '0;
                     seg_in   = '0;
                  end
                  state_in = ST_EMIT;
               end else begin
                  wr_en        = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
                  key_in       = req_key;
                  r_in         = r_cur;
                  end_in       = req_set_end;
                  dx_in        = req_key - xl_ff;
                  brk_pend_in  = (r_cur == '0);
                  brk_pos_in   = '0;
                  tail_pend_in = req_set_end;
                  tail_pos_in  = r_cur;
                  tail_fin_in  = 1'b1;
                  tail_ovf_in  = 1'b0;
                  if (r_cur == '0) begin
                     xl_in = req_key;
                  end
                  if (r_cur >= ADDR_W'(2) && req_key != xl_ff) begin
                     state_in = ST_LIMIT;
                  end else begin
                     // No interior key to test, or degenerate line.
                     prev_key_in = req_key;
                     if (req_set_end) begin
                        count_in = '0;
                        seg_in   = '0;
                     end
                     state_in = ST_EMIT;
                  end
               end
            end
         end

         ST_LIMIT: begin
            // Scale the threshold by dx; fetch the first interior key.
            ctrl.op       = OP_LIMIT;
            ctrl.acc_load = 1'b1;
            rd_en         = 1'b1;
            rd_addr       = seg_ff + ADDR_W'(1);
            idx_in        = seg_ff + ADDR_W'(1);
            state_in      = ST_MUL;
         end

         ST_MUL: begin
            ctrl.op  = OP_ERROR;
            state_in = ST_CHK;
         end

         ST_CHK: begin
            if (exceeds || (idx_ff + ADDR_W'(1) == r_ff)) begin
               if (exceeds) begin
                  // Break the segment at the previous position.
                  brk_pend_in = 1'b1;
                  brk_pos_in  = r_ff - ADDR_W'(1);
                  seg_in      = r_ff - ADDR_W'(1);
                  xl_in       = prev_key_ff;
               end
               prev_key_in = key_ff;
               if (end_ff) begin
                  count_in = '0;
                  seg_in   = '0;
               end
               state_in = ST_EMIT;
            end else begin
               // Advance to the next interior key.
               idx_in        = idx_ff + ADDR_W'(1);
               ctrl.acc_step = 1'b1;
               rd_en         = 1'b1;
               state_in      = ST_MUL;
            end
         end

         ST_EMIT: begin
            if (!brk_pend_ff && !tail_pend_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (brk_pend_ff) begin
                  rsp_boundary_in = BOUNDARY_W'(brk_pos_ff);
                  rsp_final_in    = 1'b0;
                  rsp_ovf_in      = 1'b0;
                  rsp_last_in     = !tail_pend_ff;
                  brk_pend_in     = 1'b0;
                  if (!tail_pend_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_boundary_in = BOUNDARY_W'(tail_pos_ff);
                  rsp_final_in    = tail_fin_ff;
                  rsp_ovf_in      = tail_ovf_ff;
                  rsp_last_in     = 1'b1;
                  tail_pend_in    = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seg_ff       <= '0;
         brk_pend_ff  <= 1'b0;
         tail_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         seg_ff       <= seg_in;
         brk_pend_ff  <= brk_pend_in;
         tail_pend_ff <= tail_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      xl_ff           <= xl_in;
      prev_key_ff     <= prev_key_in;
      key_ff          <= key_in;
      dx_ff           <= dx_in;
      r_ff            <= r_in;
      idx_ff          <= idx_in;
      end_ff          <= end_in;
      brk_pos_ff      <= brk_pos_in;
      tail_pos_ff     <= tail_pos_in;
      tail_fin_ff     <= tail_fin_in;
      tail_ovf_ff     <= tail_ovf_in;
      rsp_boundary_ff <= rsp_boundary_in;
      rsp_final_ff    <= rsp_final_in;
      rsp_ovf_ff      <= rsp_ovf_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_boundary       = rsp_boundary_ff;
   assign rsp_final_boundary = rsp_final_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   `GPWL_ASSERT_IMP(a_idle_drained, clock, reset, state_ff == ST_IDLE,
                    !brk_pend_ff && !tail_pend_ff, "idle with a response still pending")
   `GPWL_ASSERT_IMP(a_scan_window, clock, reset,
                    state_ff == ST_MUL || state_ff == ST_CHK,
                    idx_ff > seg_ff && idx_ff < r_ff, "scan index outside the open segment")
   `GPWL_ASSERT_NXT(a_break_start, clock, reset, state_ff == ST_CHK && exceeds && !end_ff,
                    seg_ff == $past(r_ff) - ADDR_W'(1), "break did not move segment start")
   `GPWL_ASSERT_IMP(a_final_is_last, clock, reset, rsp_valid_ff && rsp_final_ff,
                    rsp_last_ff, "closing boundary not marked last of run")

endmodule

`default_nettype wire

### rtl/core/gpwl_key_ram.sv
// Key store: single write port, single registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module gpwl_key_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/gpwl_err_unit.sv
// Shared multiply / compare unit: error limit, per-key cross product and test.
// Depends on gpwl_pkg.
`default_nettype none

module gpwl_err_unit import gpwl_pkg::*; #(
   parameter int ADDR_W    = 12,
   parameter int FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  err_ctrl_type        ctrl_i,
   input  logic [THRESH_W-1:0] threshold,
   input  logic [KEY_W-1:0]    dx,
   input  logic [KEY_W-1:0]    key_i,
   input  logic [KEY_W-1:0]    key_l,
   input  logic [ADDR_W-1:0]   span,
   output logic                exceeds
);

   localparam int MB    = (ADDR_W > THRESH_W) ? ADDR_W : THRESH_W;
   localparam int PW    = KEY_W + MB + 2;
   localparam int ACC_W = ADDR_W + KEY_W;
   localparam int EW    = (ADDR_W + KEY_W + 3 > LIMIT_W + 2) ?
                          (ADDR_W + KEY_W + 3) : (LIMIT_W + 2);

   logic signed [KEY_W:0]  mul_a;
   logic signed [MB:0]     mul_b;
   logic signed [PW-1:0]   prod_in;
   logic signed [PW-1:0]   prod_ff;
   op_type                 op_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic signed [EW-1:0]   err;
   logic [EW-1:0]          mag;

   // Select operands for the one multiplier.
   always_comb begin
      unique case (ctrl_i.op)
         OP_LIMIT: begin
            mul_a = $signed({1'b0, dx});
            mul_b = $signed({1'b0, MB'(threshold)});
         end
         OP_ERROR: begin
            mul_a = $signed({1'b0, key_i}) - $signed({1'b0, key_l});
            mul_b = $signed({1'b0, MB'(span)});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NONE;
      end else begin
         op_ff <= ctrl_i.op;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_i.op != OP_NONE) begin
         prod_ff <= prod_in;
      end
      if (op_ff == OP_LIMIT) begin
         limit_ff <= LIMIT_W'($unsigned(prod_ff) >> FRAC_BITS);
      end
      if (ctrl_i.acc_load) begin
         acc_ff <= ACC_W'(dx);
      end else if (ctrl_i.acc_step) begin
         acc_ff <= acc_ff + ACC_W'(dx);
      end
   end

   // e = span * (x_i - x_l) - (i - l) * dx, tested against the limit.
   assign err     = EW'(prod_ff) - $signed(EW'(acc_ff));
   assign mag     = err[EW-1] ? $unsigned(-err) : $unsigned(err);
   assign exceeds = (mag > EW'(limit_ff));

endmodule

`default_nettype wire

### verif/greedy_pwl_segmenter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for greedy_pwl_segmenter_core: streams key sets and
// threshold writes, predicts every segment boundary and checks responses in order.
// Depends on gpwl_pkg and the segmenter RTL only.

module greedy_pwl_segmenter_core_tb;
   import gpwl_pkg::*;

   localparam int MAX_POINTS    = 4096;
   localparam int FRAC_BITS     = 8;
   localparam int IDLE_LIMIT    = 5000;  // cycles without any transaction
   localparam int SETTLE_CYCLES = 64;    // quiet time before a threshold write
   localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
   localparam int RANDOM_KEYS   = 600;

   typedef logic [KEY_W-1:0] key_queue_type [$];

   typedef struct packed {
      logic [BOUNDARY_W-1:0] boundary;
      logic                  is_final;
      logic                  overflow;
      logic                  last_of_run;
   } boundary_type;

   // Boundary predictor and ordered store of the boundaries still owed.
   class boundary_scoreboard;
      logic [KEY_W-1:0]    key_mem [MAX_POINTS];
      int unsigned         seg_start;
      int unsigned         n_keys;
      logic [THRESH_W-1:0] threshold;
      boundary_type        pending [$];
      int unsigned         errors;
      int unsigned         n_checked;
      int unsigned         n_dropped;
      int unsigned         n_sets;

      function new();
         threshold = THRESH_RESET;
         seg_start = 0;
         n_keys    = 0;
         errors    = 0;
         n_checked = 0;
         n_dropped = 0;
         n_sets    = 0;
      endfunction

      function void set_threshold(logic [THRESH_W-1:0] value);
         threshold = value;
      endfunction

      function void clear_set();
         seg_start = 0;
         n_keys    = 0;
         n_sets++;
      endfunction

      function boundary_type make_boundary(int unsigned pos, logic is_final, logic ovf);
         boundary_type b;
         b.boundary    = pos[BOUNDARY_W-1:0];
         b.is_final    = is_final;
         b.overflow    = ovf;
         b.last_of_run = 1'b0;
         return b;
      endfunction

      // Cross-multiplied fit test of every interior key against the chord
      // from the segment start to position r; no division, and only the limit is truncated.
      function bit fit_breaks(int unsigned r);
         logic [KEY_W-1:0]  xl;
         logic [KEY_W-1:0]  dx;
         longint unsigned   limit;
         longint unsigned   mag;
         longint            span;
         longint            di;
         longint            err;
         xl = key_mem[seg_start];
         dx = key_mem[r] - xl;
         if (dx == '0)
            return 1'b0;
         limit = ({48'h0, threshold} * {32'h0, dx}) >> FRAC_BITS;
         span  = longint'(r - seg_start);
         for (int unsigned i = seg_start + 1; i < r; i++) begin
            di  = longint'({32'h0, key_mem[i]}) - longint'({32'h0, xl});
            err = span * di - longint'(i - seg_start) * longint'({32'h0, dx});
            mag = (err < 0) ? -err : err;
            if (mag > limit)
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_key(logic [KEY_W-1:0] key, logic set_end);
         boundary_type run [2];
         int           cnt;
         int unsigned  r;
         cnt = 0;
         if (n_keys >= MAX_POINTS) begin
            run[cnt] = make_boundary(set_end ? MAX_POINTS - 1 : 0, set_end, 1'b1);
            cnt++;
            n_dropped++;
            if (set_end)
               clear_set();
         end else begin
            r          = n_keys;
            key_mem[r] = key;
            n_keys     = r + 1;
            if (r == 0) begin
               run[cnt] = make_boundary(0, 1'b0, 1'b0);
               cnt++;
            end else if (r >= 2 && fit_breaks(r)) begin
               run[cnt]  = make_boundary(r - 1, 1'b0, 1'b0);
               cnt++;
               seg_start = r - 1;
            end
            if (set_end) begin
               run[cnt] = make_boundary(r, 1'b1, 1'b0);
               cnt++;
               clear_set();
            end
         end
         for (int k = 0; k < cnt; k++) begin
            if (k == cnt - 1)
               run[k].last_of_run = 1'b1;
            pending = {pending, run[k]};
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(boundary_type got);
         boundary_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response, boundary %0d", got.boundary));
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (got.boundary !== want.boundary)
            report($sformatf("boundary %0d, want %0d", got.boundary, want.boundary));
         if (got.is_final !== want.is_final)
            report($sformatf("final_boundary %b, want %b at boundary %0d",
                             got.is_final, want.is_final, want.boundary));
         if (got.overflow !== want.overflow)
            report($sformatf("overflow %b, want %b at boundary %0d",
                             got.overflow, want.overflow, want.boundary));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b at boundary %0d",
                             got.last_of_run, want.last_of_run, want.boundary));
      endtask
   endclass

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [KEY_W-1:0]      req_key            = '0;
   logic                  req_set_end        = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [BOUNDARY_W-1:0] rsp_boundary;
   logic                  rsp_final_boundary;
   logic                  rsp_overflow;
   logic                  rsp_last_of_run;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [THRESH_W-1:0]   csr_data           = '0;

   boundary_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned n_sent        = 0;
   int unsigned n_csr         = 0;
   int unsigned hold_req      = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned idle_cycles   = 0;

   greedy_pwl_segmenter_core #(
      .MAX_POINTS       (MAX_POINTS),
      .THRESH_FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key            (req_key),
      .req_set_end        (req_set_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_boundary       (rsp_boundary),
      .rsp_final_boundary (rsp_final_boundary),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: check each accepted transaction against the oldest
   // prediction, then pick the next ready. A hold request from the stimulus
   // side starts a long stall, counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_boundary, rsp_final_boundary, rsp_overflow,
                               rsp_last_of_run});
         if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: abandon the run if no channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("** greedy_pwl_segmenter_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one key; valid stays high across back-to-back keys so it is never
   // dropped and raised in the same step.
   task automatic send_key(logic [KEY_W-1:0] key, logic set_end);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_key     <= key;
      req_set_end <= set_end;
      do @(posedge clock); while (!req_ready);
      sb.note_key(key, set_end);
      n_sent++;
   endtask

   // Withdraw the sender and wait for every owed boundary, then let the
   // block settle for the given number of cycles.
   task automatic drain(int unsigned settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THRESH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_threshold(value);
      n_csr++;
   endtask

   // Send one set, set_end on the last key; optionally pause mid-set until
   // the block has delivered everything owed so far.
   task automatic send_keys(key_queue_type keys, int pause_at);
      for (int i = 0; i < keys.size(); i++) begin
         if (i == pause_at)
            drain(0);
         send_key(keys[i], i == keys.size() - 1);
      end
   endtask

   // Mostly short sorted sets; near-linear runs with noise of up to two
   // positions give a mix of kept and broken segments. A few long sets,
   // duplicate runs and fully shuffled sets make up the rest.
   function automatic key_queue_type random_key_set();
      key_queue_type    keys;
      int unsigned      len;
      int unsigned      pick;
      int unsigned      slope;
      int unsigned      spread;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(99);
      if (pick < 5)
         len = $urandom_range(60, 200);
      else if (pick < 15)
         len = 1;
      else
         len = $urandom_range(2, 24);
      pick   = $urandom_range(99);
      k      = (pick < 50) ? $urandom_range(0, 32'hF000_0000) : $urandom;
      slope  = $urandom_range(1, 4000);
      spread = $urandom_range(0, 2 * slope);
      for (int unsigned i = 0; i < len; i++) begin
         if (pick < 50) begin
            keys = {keys, k + slope * i + $urandom_range(0, spread)};
         end else if (pick < 75) begin
            k = k + $urandom_range(0, 1 << $urandom_range(0, 20));
            keys = {keys, k};
         end else if (pick < 87) begin
            if ($urandom_range(2) == 0)
               k = k + $urandom_range(1, 50);
            keys = {keys, k};
         end else begin
            keys = {keys, $urandom};
         end
      end
      return keys;
   endfunction

   task automatic random_phase(int unsigned n_items, bit long_hold, bit mid_pause);
      key_queue_type keys;
      int unsigned   sent0;
      sent0 = n_sent;
      while (n_sent - sent0 < n_items) begin
         keys = random_key_set();
         if (long_hold) begin
            hold_req  <= hold_req + 1;
            long_hold = 1'b0;
         end
         if (mid_pause && keys.size() > 4) begin
            send_keys(keys, keys.size() / 2);
            mid_pause = 1'b0;
         end else begin
            send_keys(keys, -1);
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 28;
      recv_idle_pct = 61;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed sets at the reset threshold of half a position.
      send_keys('{32'd0}, -1);                                    // lone key
      send_keys('{32'd0, 32'd100, 32'd200, 32'd301, 32'hFFFF_FFFF}, -1);
      send_keys('{32'd7, 32'd7, 32'd7, 32'd7}, -1);                // flat chord
      send_keys('{32'd5000, 32'd10, 32'h8000_0000, 32'd3, 32'd6000}, -1);
      drain(SETTLE_CYCLES);
      write_threshold('0);
      send_keys('{32'd0, 32'd10, 32'd20, 32'd30, 32'd45}, -1);     // exact line, then off
      drain(SETTLE_CYCLES);
      write_threshold('1);
      send_keys('{32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd1}, -1); // wrapping chord
      drain(SETTLE_CYCLES);

      // Random sets: sender idles lightly, receiver heavily.
      write_threshold(THRESH_W'($urandom_range(1, 1023)));
      random_phase(RANDOM_KEYS / 3, 1'b0, 1'b1);
      drain(SETTLE_CYCLES);

      // Roles swapped, widest threshold, with one long receiver stall.
      send_idle_pct = 61;
      recv_idle_pct = 28;
      write_threshold(16'hFFFF);
      random_phase(RANDOM_KEYS / 3, 1'b1, 1'b0);
      drain(SETTLE_CYCLES);

      // No idling on either side, random threshold.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(THRESH_W'($urandom_range(0, 16'hFFFF)));
      random_phase(RANDOM_KEYS / 3, 1'b0, 1'b0);
      drain(SETTLE_CYCLES);

      $display("Run covered %0d keys in %0d sets with %0d threshold writes;",
               n_sent, sb.n_sets, n_csr);
      $display("%0d boundaries checked, %0d dropped keys, under three idling mixes.",
               sb.n_checked, sb.n_dropped);
      if (sb.errors == 0) begin
         $display("** greedy_pwl_segmenter_core: PASSED **");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("** greedy_pwl_segmenter_core: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gpwl_pkg.sv
rtl/core/gpwl_key_ram.sv
rtl/core/gpwl_err_unit.sv
rtl/core/greedy_pwl_segmenter_core.sv
verif/greedy_pwl_segmenter_core_tb.sv
